/* design/ealu_pkg.sv */
// shared types and constants for the eight-bit alu with chunked opcode
// no dependencies
`default_nettype none

package ealu_pkg;

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned OPCODE_W   = 5;
    localparam int unsigned SEL_W      = 4;
    localparam int unsigned CNT_W      = 2;
    localparam int unsigned LOGIC_BIT  = 4;
    localparam int unsigned DIV_STEPS  = 8;
    localparam logic [CNT_W-1:0] CNT_LAST_CHUNK = 2'd2;

    typedef enum logic [1:0] {
        FUNC_CALC  = 2'd0,
        FUNC_SHIFT = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [3:0] {
        AR_ZERO      = 4'd0,
        AR_DIV       = 4'd1,
        AR_MUL_DEC   = 4'd2,
        AR_ADD       = 4'd3,
        AR_SQ_DIFF   = 4'd4,
        AR_DOUBLE    = 4'd5,
        AR_AVG       = 4'd6,
        AR_MUL       = 4'd7,
        AR_MOD       = 4'd8,
        AR_HALF      = 4'd9,
        AR_MUL_SUB   = 4'd10,
        AR_SUB       = 4'd11,
        AR_DIFF_SQ   = 4'd12,
        AR_PASS_A    = 4'd13,
        AR_SQUARE    = 4'd14,
        AR_DEC       = 4'd15
    } arith_op_t;

    typedef enum logic [3:0] {
        LG_NOT_A     = 4'd0,
        LG_NAND      = 4'd1,
        LG_NOTA_OR_B = 4'd2,
        LG_ONE       = 4'd3,
        LG_XOR       = 4'd4,
        LG_NOT_EQ    = 4'd5,
        LG_LE        = 4'd6,
        LG_OR        = 4'd7,
        LG_NOT_LE    = 4'd8,
        LG_NAND_ALT  = 4'd9,
        LG_AND       = 4'd10,
        LG_XNOR      = 4'd11,
        LG_NOT_B     = 4'd12,
        LG_NOR       = 4'd13,
        LG_EQ        = 4'd14,
        LG_XNOR_ALT  = 4'd15
    } logic_op_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_MUL1  = 3'd1,
        ST_MUL2  = 3'd2,
        ST_DIV   = 3'd3,
        ST_WRITE = 3'd4
    } state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic div_step;
        logic write;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_mul2;
        logic need_div;
        logic div_last;
        logic out_free;
    } ctrl_stat_t;

endpackage

`default_nettype wire

/* design/ealu_div.sv */
// restoring divider, one quotient bit per cycle while step is high
// depends on ealu_pkg
`default_nettype none

module ealu_div
    import ealu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic              step,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic      [DATA_W-1:0] quotient,
    output logic      [DATA_W-1:0] remainder,
    output logic                   last
);

    localparam int unsigned CW = $clog2(DIV_STEPS);

    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]     cnt_reg;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DATA_W-1]};
        fits     = trial >= {1'b0, divisor};
        diff     = trial - {1'b0, divisor};
        rem_next = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        quo_next = {quo_reg[DATA_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign last      = cnt_reg == CW'(DIV_STEPS - 1);

endmodule

`default_nettype wire

/* design/ealu_ctrl.sv */
// controller state machine: sequences load, multiply, divide and write
// depends on ealu_pkg
`default_nettype none

module ealu_ctrl
    import ealu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire ctrl_stat_t stat,
    output ctrl_cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1 = 1'b1;
                if (stat.need_mul2)
                begin
                    state_next = ST_MUL2;
                end
                else if (stat.need_div)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (stat.out_free)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/ealu_datapath.sv */
// datapath: operand and opcode registers, shared multiplier, divider, output register
// depends on ealu_pkg and ealu_div
`default_nettype none

module ealu_datapath
    import ealu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [1:0]          func,
    input  wire logic [1:0]          opcode_chunk,
    input  wire logic [DATA_W-1:0]   operand_a,
    input  wire logic [DATA_W-1:0]   operand_b,
    input  wire ctrl_cmd_t           cmd,
    output ctrl_stat_t               stat,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [DATA_W-1:0]        result,
    output logic                     div_by_zero,
    output logic [OPCODE_W-1:0]      opcode_now
);

    func_t               func_reg;
    logic [1:0]          chunk_reg;
    logic [DATA_W-1:0]   a_reg, b_reg;
    logic [DATA_W-1:0]   p1_reg, p2_reg;
    logic [OPCODE_W-1:0] opcode_reg, opcode_next;
    logic [CNT_W-1:0]    chunk_cnt_reg, chunk_cnt_next;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   result_reg, result_next;
    logic                dz_reg, dz_next;
    logic [OPCODE_W-1:0] opcode_out_reg;

    logic                is_calc, is_logic;
    arith_op_t           arith_sel;
    logic_op_t           logic_sel;
    logic [DATA_W-1:0]   a_minus_b;
    logic [DATA_W:0]     sum_ab;
    logic [DATA_W-1:0]   mul_x, mul_y;
    logic [2*DATA_W-1:0] product;
    logic                b_zero;
    logic [DATA_W-1:0]   quotient, remainder;
    logic                div_last;

    ealu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.load),
        .step      (cmd.div_step),
        .dividend  (operand_a),
        .divisor   (b_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .last      (div_last)
    );

    assign is_calc   = func_reg == FUNC_CALC;
    assign is_logic  = opcode_reg[LOGIC_BIT];
    assign arith_sel = arith_op_t'(opcode_reg[SEL_W-1:0]);
    assign logic_sel = logic_op_t'(opcode_reg[SEL_W-1:0]);
    assign a_minus_b = a_reg - b_reg;
    assign sum_ab    = {1'b0, a_reg} + {1'b0, b_reg};
    assign b_zero    = b_reg == '0;

    // shared multiplier, only the low byte matters
    always_comb
    begin
        mul_x = a_reg;
        mul_y = b_reg;
        if (cmd.mul2)
        begin
            mul_x = b_reg;
            mul_y = b_reg;
        end
        else if (arith_sel == AR_DIFF_SQ)
        begin
            mul_x = a_minus_b;
            mul_y = a_minus_b;
        end
        else if (arith_sel == AR_SQ_DIFF || arith_sel == AR_SQUARE)
        begin
            mul_x = a_reg;
            mul_y = a_reg;
        end
    end

    assign product = mul_x * mul_y;

    always_comb
    begin
        stat.need_mul2 = is_calc && !is_logic && arith_sel == AR_SQ_DIFF;
        stat.need_div  = is_calc && !is_logic && !b_zero
                         && (arith_sel == AR_DIV || arith_sel == AR_MOD);
        stat.div_last  = div_last;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // opcode assembly
    always_comb
    begin
        opcode_next    = opcode_reg;
        chunk_cnt_next = chunk_cnt_reg;
        case (func_reg)
            FUNC_SHIFT:
            begin
                if (chunk_cnt_reg >= CNT_LAST_CHUNK)
                begin
                    opcode_next    = {opcode_reg[OPCODE_W-2:0], chunk_reg[0]};
                    chunk_cnt_next = '0;
                end
                else
                begin
                    opcode_next    = {opcode_reg[OPCODE_W-3:0], chunk_reg};
                    chunk_cnt_next = chunk_cnt_reg + CNT_W'(1);
                end
            end
            FUNC_CLEAR:
            begin
                opcode_next    = '0;
                chunk_cnt_next = '0;
            end
            default:
            begin
                opcode_next    = opcode_reg;
                chunk_cnt_next = chunk_cnt_reg;
            end
        endcase
    end

    // result select
    always_comb
    begin
        result_next = '0;
        dz_next     = 1'b0;
        if (is_calc && is_logic)
        begin
            unique case (logic_sel) inside
                LG_NOT_A:     result_next = ~a_reg;
                LG_NAND,
                LG_NAND_ALT:  result_next = ~(a_reg & b_reg);
                LG_NOTA_OR_B: result_next = ~a_reg | b_reg;
                LG_ONE:       result_next = DATA_W'(1);
                LG_XOR:       result_next = a_reg ^ b_reg;
                LG_NOT_EQ:    result_next = (a_reg == b_reg) ? 8'hFE : 8'hFF;
                LG_LE:        result_next = DATA_W'(a_reg <= b_reg);
                LG_OR:        result_next = a_reg | b_reg;
                LG_NOT_LE:    result_next = (a_reg <= b_reg) ? 8'hFE : 8'hFF;
                LG_AND:       result_next = a_reg & b_reg;
                LG_XNOR,
                LG_XNOR_ALT:  result_next = ~(a_reg ^ b_reg);
                LG_NOT_B:     result_next = ~b_reg;
                LG_NOR:       result_next = ~(a_reg | b_reg);
                LG_EQ:        result_next = DATA_W'(a_reg == b_reg);
                default:      result_next = '0;
            endcase
        end
        else if (is_calc)
        begin
            unique case (arith_sel) inside
                AR_ZERO:    result_next = '0;
                AR_DIV:
                begin
                    result_next = b_zero ? '0 : quotient;
                    dz_next     = b_zero;
                end
                AR_MUL_DEC: result_next = p1_reg - DATA_W'(1);
                AR_ADD:     result_next = sum_ab[DATA_W-1:0];
                AR_SQ_DIFF: result_next = p1_reg - p2_reg;
                AR_DOUBLE:  result_next = {a_reg[DATA_W-2:0], 1'b0};
                AR_AVG:     result_next = sum_ab[DATA_W:1];
                AR_MUL,
                AR_DIFF_SQ,
                AR_SQUARE:  result_next = p1_reg;
                AR_MOD:
                begin
                    result_next = b_zero ? '0 : remainder;
                    dz_next     = b_zero;
                end
                AR_HALF:    result_next = {1'b0, a_reg[DATA_W-1:1]};
                AR_MUL_SUB: result_next = p1_reg - sum_ab[DATA_W-1:0];
                AR_SUB:     result_next = a_minus_b;
                AR_PASS_A:  result_next = a_reg;
                AR_DEC:     result_next = a_reg - DATA_W'(1);
                default:    result_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func_t'(func);
            chunk_reg <= opcode_chunk;
            a_reg     <= operand_a;
            b_reg     <= operand_b;
        end
        if (cmd.mul1)
        begin
            p1_reg <= product[DATA_W-1:0];
        end
        if (cmd.mul2)
        begin
            p2_reg <= product[DATA_W-1:0];
        end
        if (cmd.write)
        begin
            result_reg     <= result_next;
            dz_reg         <= dz_next;
            opcode_out_reg <= opcode_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg    <= '0;
            chunk_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                opcode_reg    <= opcode_next;
                chunk_cnt_reg <= chunk_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result      = result_reg;
    assign div_by_zero = dz_reg;
    assign opcode_now  = opcode_out_reg;

`ifndef SYNTHESIS
    a_chunk_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_cnt_reg != 2'd3)
        else $error("chunk count out of range");

    a_write_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> stat.out_free)
        else $error("output word overwritten");

    a_dz_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dz_reg |-> result_reg == '0)
        else $error("divide by zero with nonzero result");

    a_div_only_for_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> stat.need_div)
        else $error("divider stepped for non-divide op");
`endif

endmodule

`default_nettype wire

/* design/eight_bit_alu_with_chunked_opcode_top.sv */
// sequence: accept, first multiply, then a second multiply for a*a-b*b or eight restoring
// divider steps for divide and modulo with a nonzero divisor, then write of the output word
// one item in flight at a time; the write waits until the output register is free
// output register holds a finished word while the next input word is taken
// reset: asynchronous active-low rst_n clears opcode, chunk count, fsm and output valid
// top level: controller and datapath; depends on ealu_pkg, ealu_ctrl, ealu_datapath
`default_nettype none

module eight_bit_alu_with_chunked_opcode_top
    import ealu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // opcode_chunk, operand_a, operand_b, unused upper bits
    input  wire logic [1:0]  s_axis_tuser,  // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // result, opcode_now, zero pad
    output logic             m_axis_tuser   // div_by_zero
);

    ctrl_cmd_t           cmd;
    ctrl_stat_t          stat;
    logic [DATA_W-1:0]   result;
    logic [OPCODE_W-1:0] opcode_now;

    ealu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ealu_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (s_axis_tuser),
        .opcode_chunk (s_axis_tdata[1:0]),
        .operand_a    (s_axis_tdata[9:2]),
        .operand_b    (s_axis_tdata[17:10]),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .result       (result),
        .div_by_zero  (m_axis_tuser),
        .opcode_now   (opcode_now)
    );

    assign m_axis_tdata = {3'b000, opcode_now, result};

endmodule

`default_nettype wire
